>>> design/i2c_master_packet_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master packet sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_PACKET_SEQUENCER_MACROS_SVH
`define I2C_MASTER_PACKET_SEQUENCER_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define I2CMS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check violated");

`endif

>>> design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master packet sequencer package
// Opcodes, bus commands, status codes, phases and the item structures.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_START_WRITE = 2'd0,
      OP_START_READ  = 2'd1,
      OP_ACK_REPORT  = 2'd2,
      OP_RX_BYTE     = 2'd3
   } opcode_type;

   // Commands issued to the byte engine.
   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_SEND  = 3'd1,
      CMD_READ  = 3'd2,
      CMD_ACK   = 3'd3,
      CMD_NACK  = 3'd4,
      CMD_STOP  = 3'd5
   } bus_cmd_type;

   // Transaction status.
   typedef enum logic [1:0] {
      ST_GO   = 2'd0,
      ST_OK   = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   // Sequencer phases, one-hot.
   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_W_ADDR   = 7'b0000010,
      PH_W_DATA   = 7'b0000100,
      PH_R_ADDR   = 7'b0001000,
      PH_R_FIRST  = 7'b0010000,
      PH_R_SECOND = 7'b0100000,
      PH_R_REST   = 7'b1000000
   } phase_type;

   // Read address bit and the flag bit of the first read byte.
   localparam logic [7:0] READ_BIT_MASK = 8'h01;
   localparam int         FLAG_BIT      = 7;
   // Bytes following a first byte that has the flag bit set.
   localparam logic [7:0] FIXED_TAIL_LEN = 8'd2;

   // One request beat.
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  address_byte;
      logic [7:0]  write_length;
      logic        ack_bit;
      logic [7:0]  rx_byte;
      logic [7:0]  tx_byte;
   } req_item_type;

   // One response beat.
   typedef struct packed {
      bus_cmd_type bus_command;
      logic [7:0]  tx_value;
      logic [7:0]  rx_data;
      logic        rx_valid;
      status_type  status;
      logic        last;
   } rsp_item_type;

   // Up to two responses caused by one request.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_batch_type;

endpackage

>>> design/i2cms_in_stage.sv
// ----------------------------------------------------------------------------
// I2C master packet sequencer input stage
// Registers one request beat and frees itself as the beat is consumed.
// ----------------------------------------------------------------------------
module i2cms_in_stage
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         consume,
   output logic         held_valid,
   output req_item_type held_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // The stage takes a new beat when empty or when its beat leaves now.
   assign req_ready = !valid_ff || consume;
   assign valid_in  = req_valid || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

>>> design/i2cms_engine.sv
// ----------------------------------------------------------------------------
// I2C master packet sequencer engine
// Holds the transaction phase and byte count and decides the responses.
// ----------------------------------------------------------------------------
`include "i2c_master_packet_sequencer_macros.svh"

module i2cms_engine
   import i2cms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  item,
   input  logic          consume,
   output rsp_batch_type batch
);

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] bytes_left_ff;
   logic [7:0] bytes_left_in;

   rsp_item_type r0;
   rsp_item_type r1;
   logic [1:0]   count;

   // Decision for the held request against the current phase.
   always_comb begin
      r0            = '0;
      r1            = '0;
      count         = 2'd0;
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      unique case (item.opcode)
         OP_START_WRITE, OP_START_READ: begin
            count          = 2'd2;
            r0.bus_command = CMD_START;
            r1.bus_command = CMD_SEND;
            r1.last        = 1'b1;
            if (item.opcode == OP_START_WRITE) begin
               r1.tx_value   = item.address_byte;
               bytes_left_in = item.write_length;
               phase_in      = PH_W_ADDR;
            end else begin
               r1.tx_value   = item.address_byte | READ_BIT_MASK;
               bytes_left_in = 8'd0;
               phase_in      = PH_R_ADDR;
            end
         end
         OP_ACK_REPORT: begin
            r0.last = 1'b1;
            priority if (phase_ff == PH_W_ADDR || phase_ff == PH_W_DATA) begin
               count = 2'd1;
               priority if (item.ack_bit) begin
                  r0.bus_command = CMD_STOP;
                  r0.status      = ST_FAIL;
                  phase_in       = PH_IDLE;
               end else if (bytes_left_ff == 8'd0) begin
                  r0.bus_command = CMD_STOP;
                  r0.status      = ST_OK;
                  phase_in       = PH_IDLE;
               end else begin
                  r0.bus_command = CMD_SEND;
                  r0.tx_value    = item.tx_byte;
                  bytes_left_in  = bytes_left_ff - 8'd1;
                  phase_in       = PH_W_DATA;
               end
            end else if (phase_ff == PH_R_ADDR) begin
               count = 2'd1;
               if (item.ack_bit) begin
                  r0.bus_command = CMD_STOP;
                  r0.status      = ST_FAIL;
                  phase_in       = PH_IDLE;
               end else begin
                  r0.bus_command = CMD_READ;
                  phase_in       = PH_R_FIRST;
               end
            end else begin
               // A report the current phase does not wait for is dropped.
               r0.last = 1'b0;
            end
         end
         OP_RX_BYTE: begin
            r0.rx_data     = item.rx_byte;
            r0.rx_valid    = 1'b1;
            r0.bus_command = CMD_ACK;
            r1.bus_command = CMD_READ;
            r1.last        = 1'b1;
            priority if (phase_ff == PH_R_FIRST) begin
               count = 2'd2;
               if (item.rx_byte[FLAG_BIT]) begin
                  bytes_left_in = FIXED_TAIL_LEN;
                  phase_in      = PH_R_REST;
               end else begin
                  phase_in      = PH_R_SECOND;
               end
            end else if (phase_ff == PH_R_SECOND) begin
               count = 2'd2;
               if (item.rx_byte[FLAG_BIT]) begin
                  // A length of 128 or more is refused.
                  r0.bus_command = CMD_NACK;
                  r1.bus_command = CMD_STOP;
                  r1.status      = ST_FAIL;
                  phase_in       = PH_IDLE;
               end else begin
                  // Data bytes plus the trailing CRC byte.
                  bytes_left_in = item.rx_byte + 8'd1;
                  phase_in      = PH_R_REST;
               end
            end else if (phase_ff == PH_R_REST) begin
               count = 2'd2;
               if (bytes_left_ff <= 8'd1) begin
                  r0.bus_command = CMD_NACK;
                  r1.bus_command = CMD_STOP;
                  r1.status      = ST_OK;
                  bytes_left_in  = 8'd0;
                  phase_in       = PH_IDLE;
               end else begin
                  bytes_left_in  = bytes_left_ff - 8'd1;
               end
            end else begin
               // A byte the current phase does not wait for is dropped.
               r0 = '0;
               r1 = '0;
            end
         end
         default: begin
            count = 2'd0;
         end
      endcase
   end

   assign batch.count  = count;
   assign batch.first  = r0;
   assign batch.second = r1;

   // State advances only when the request is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= 8'd0;
      end else if (consume) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   `I2CMS_ASSERT_ALWAYS(a_phase_onehot, clock, reset, $onehot(phase_ff))
   `I2CMS_ASSERT_ALWAYS(a_status_only_on_stop, clock, reset,
      (count == 2'd0) || (r0.status == ST_GO || r0.bus_command == CMD_STOP))
   `I2CMS_ASSERT_ALWAYS(a_rx_on_ack_nack, clock, reset,
      (count == 2'd0) || !r0.rx_valid || r0.bus_command == CMD_ACK || r0.bus_command == CMD_NACK)

endmodule

>>> design/i2cms_rsp_queue.sv
// ----------------------------------------------------------------------------
// I2C master packet sequencer response queue
// Two-entry output buffer that takes a batch of up to two responses.
// ----------------------------------------------------------------------------
`include "i2c_master_packet_sequencer_macros.svh"

module i2cms_rsp_queue
   import i2cms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rsp_batch_type batch,
   input  logic          load,
   output logic [1:0]    space,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  head
);

   logic [1:0]   cnt_ff;
   logic [1:0]   cnt_in;
   rsp_item_type head_ff;
   rsp_item_type head_in;
   rsp_item_type tail_ff;
   rsp_item_type tail_in;
   logic         pop;
   logic [1:0]   rem;
   rsp_item_type kept;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rem       = cnt_ff - {1'b0, pop};
   assign space     = 2'd2 - rem;
   assign kept      = pop ? tail_ff : head_ff;

   // Remaining entries stay in order; the new batch goes behind them.
   always_comb begin
      head_in = kept;
      tail_in = tail_ff;
      cnt_in  = rem;
      if (load) begin
         cnt_in = rem + batch.count;
         if (rem == 2'd0) begin
            head_in = batch.first;
            tail_in = batch.second;
         end else if (rem == 2'd1) begin
            tail_in = batch.first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign head = head_ff;

   `I2CMS_ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= 2'd2)
   `I2CMS_ASSERT_NEXT(a_full_stall_holds, clock, reset,
      cnt_ff == 2'd2 && !rsp_ready, cnt_ff == 2'd2)

endmodule

>>> design/i2c_master_packet_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master packet sequencer
// Byte-level I2C master sequencer: turns engine reports into bus commands.
// ----------------------------------------------------------------------------
// Usage: each req_ beat carries a start opcode or a report from the byte
// engine (slave ack bit or received byte). Each beat causes zero, one or two
// rsp_ beats with a bus command, the byte to send, a received byte and the
// transaction status; rsp_last marks the final beat of one request.
// Path: a request beat is registered in the input stage, then decided and
// written to the response buffer, whose registered head drives the rsp_ ports.
// Throughput: one request per cycle while requests cause one response each
// and rsp_ready stays high; requests causing two responses are limited by the
// response channel to one beat per cycle.
// Reset: the phase returns to idle and both buffers empty.
// Stall: when rsp_ready is low the two-entry response buffer holds its beats
// and the input register holds one more request; req_ready drops once the
// buffer cannot take the held request's responses.
// ----------------------------------------------------------------------------
module i2c_master_packet_sequencer
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_address_byte,
   input  logic [7:0] req_write_length,
   input  logic       req_ack_bit,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_tx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_bus_command,
   output logic [7:0] rsp_tx_value,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_rx_valid,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   req_item_type  req_item;
   req_item_type  held_item;
   logic          held_valid;
   logic          consume;
   rsp_batch_type batch;
   logic [1:0]    space;
   rsp_item_type  head;

   // Gather the request fields.
   assign req_item.opcode       = opcode_type'(req_opcode);
   assign req_item.address_byte = req_address_byte;
   assign req_item.write_length = req_write_length;
   assign req_item.ack_bit      = req_ack_bit;
   assign req_item.rx_byte      = req_rx_byte;
   assign req_item.tx_byte      = req_tx_byte;

   i2cms_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .consume    (consume),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   i2cms_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .item    (held_item),
      .consume (consume),
      .batch   (batch)
   );

   // The held request moves on when its responses fit in the buffer.
   assign consume = held_valid && (batch.count <= space);

   i2cms_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .load      (consume),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // Spread the head response onto the ports.
   assign rsp_bus_command = head.bus_command;
   assign rsp_tx_value    = head.tx_value;
   assign rsp_rx_data     = head.rx_data;
   assign rsp_rx_valid    = head.rx_valid;
   assign rsp_status      = head.status;
   assign rsp_last        = head.last;

endmodule

>>> dv/i2c_master_packet_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master packet sequencer testbench
// Drives engine reports and start requests into the sequencer, predicts the
// bus commands that each request beat should cause, and checks every response
// beat in order. Both channels stall at random; the response side also holds
// off once for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module i2c_master_packet_sequencer_tb
   import i2cms_pkg::*;
();

   localparam int TOTAL_ITEMS   = 900;
   localparam int PRESSURE_AT   = 400;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 400000;

   // Tracks the sequencer's phase and byte count and holds the commands that
   // accepted request beats are still owed.
   class bus_cmd_scoreboard;
      phase_type    seq_phase;
      logic [7:0]   remaining;
      rsp_item_type pending_cmds[$];
      int unsigned  mismatches;

      function new();
         seq_phase  = PH_IDLE;
         remaining  = '0;
         mismatches = 0;
      endfunction

      function void push_cmd(bus_cmd_type cmd, logic [7:0] txv, logic [7:0] rxd,
                             logic rxv, status_type st, logic lst);
         rsp_item_type r;
         r.bus_command = cmd;
         r.tx_value    = txv;
         r.rx_data     = rxd;
         r.rx_valid    = rxv;
         r.status      = st;
         r.last        = lst;
         pending_cmds.push_back(r);
      endfunction

      // Work out the commands caused by one accepted request beat.
      function void note_request(req_item_type it);
         case (it.opcode)
            OP_START_WRITE: begin
               push_cmd(CMD_START, 8'h00, 8'h00, 1'b0, ST_GO, 1'b0);
               push_cmd(CMD_SEND, it.address_byte, 8'h00, 1'b0, ST_GO, 1'b1);
               remaining = it.write_length;
               seq_phase = PH_W_ADDR;
            end
            OP_START_READ: begin
               push_cmd(CMD_START, 8'h00, 8'h00, 1'b0, ST_GO, 1'b0);
               push_cmd(CMD_SEND, it.address_byte | READ_BIT_MASK, 8'h00, 1'b0,
                        ST_GO, 1'b1);
               remaining = '0;
               seq_phase = PH_R_ADDR;
            end
            OP_ACK_REPORT: begin
               if (seq_phase == PH_W_ADDR || seq_phase == PH_W_DATA) begin
                  if (it.ack_bit) begin
                     push_cmd(CMD_STOP, 8'h00, 8'h00, 1'b0, ST_FAIL, 1'b1);
                     seq_phase = PH_IDLE;
                  end else if (remaining == 8'd0) begin
                     push_cmd(CMD_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b1);
                     seq_phase = PH_IDLE;
                  end else begin
                     push_cmd(CMD_SEND, it.tx_byte, 8'h00, 1'b0, ST_GO, 1'b1);
                     remaining = remaining - 8'd1;
                     seq_phase = PH_W_DATA;
                  end
               end else if (seq_phase == PH_R_ADDR) begin
                  if (it.ack_bit) begin
                     push_cmd(CMD_STOP, 8'h00, 8'h00, 1'b0, ST_FAIL, 1'b1);
                     seq_phase = PH_IDLE;
                  end else begin
                     push_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, ST_GO, 1'b1);
                     seq_phase = PH_R_FIRST;
                  end
               end
            end
            OP_RX_BYTE: begin
               if (seq_phase == PH_R_FIRST) begin
                  push_cmd(CMD_ACK, 8'h00, it.rx_byte, 1'b1, ST_GO, 1'b0);
                  push_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, ST_GO, 1'b1);
                  if (it.rx_byte[FLAG_BIT]) begin
                     remaining = FIXED_TAIL_LEN;
                     seq_phase = PH_R_REST;
                  end else begin
                     seq_phase = PH_R_SECOND;
                  end
               end else if (seq_phase == PH_R_SECOND) begin
                  if (it.rx_byte >= 8'd128) begin
                     push_cmd(CMD_NACK, 8'h00, it.rx_byte, 1'b1, ST_GO, 1'b0);
                     push_cmd(CMD_STOP, 8'h00, 8'h00, 1'b0, ST_FAIL, 1'b1);
                     seq_phase = PH_IDLE;
                  end else begin
                     push_cmd(CMD_ACK, 8'h00, it.rx_byte, 1'b1, ST_GO, 1'b0);
                     push_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, ST_GO, 1'b1);
                     remaining = it.rx_byte + 8'd1;
                     seq_phase = PH_R_REST;
                  end
               end else if (seq_phase == PH_R_REST) begin
                  if (remaining <= 8'd1) begin
                     push_cmd(CMD_NACK, 8'h00, it.rx_byte, 1'b1, ST_GO, 1'b0);
                     push_cmd(CMD_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b1);
                     remaining = '0;
                     seq_phase = PH_IDLE;
                  end else begin
                     push_cmd(CMD_ACK, 8'h00, it.rx_byte, 1'b1, ST_GO, 1'b0);
                     push_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, ST_GO, 1'b1);
                     remaining = remaining - 8'd1;
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one response beat with the oldest command still owed.
      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (pending_cmds.size() == 0) begin
            $error("response beat with no command owed: bus_command %0d",
                   got.bus_command);
            mismatches++;
            return;
         end
         want = pending_cmds.pop_front();
         compare_field("bus_command", want.bus_command, got.bus_command);
         compare_field("tx_value", want.tx_value, got.tx_value);
         compare_field("rx_data", want.rx_data, got.rx_data);
         compare_field("rx_valid", want.rx_valid, got.rx_valid);
         compare_field("status", want.status, got.status);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_opcode;
   logic [7:0] req_address_byte;
   logic [7:0] req_write_length;
   logic       req_ack_bit;
   logic [7:0] req_rx_byte;
   logic [7:0] req_tx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_bus_command;
   logic [7:0] rsp_tx_value;
   logic [7:0] rsp_rx_data;
   logic       rsp_rx_valid;
   logic [1:0] rsp_status;
   logic       rsp_last;

   bus_cmd_scoreboard sb;
   int  items_sent;
   int  cycle_count = 0;
   bit  no_idle;
   bit  hold_rsp;
   bit  started;

   i2c_master_packet_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_address_byte (req_address_byte),
      .req_write_length (req_write_length),
      .req_ack_bit      (req_ack_bit),
      .req_rx_byte      (req_rx_byte),
      .req_tx_byte      (req_tx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bus_command  (rsp_bus_command),
      .rsp_tx_value     (rsp_tx_value),
      .rsp_rx_data      (rsp_rx_data),
      .rsp_rx_valid     (rsp_rx_valid),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #6 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Observe accepted beats on both channels.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request({req_opcode, req_address_byte, req_write_length,
                          req_ack_bit, req_rx_byte, req_tx_byte});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response({rsp_bus_command, rsp_tx_value, rsp_rx_data,
                            rsp_rx_valid, rsp_status, rsp_last});
      end
   end

   // Idle cycles before the next beat on either side; none in burst stretches.
   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic req_item_type random_item(opcode_type op);
      req_item_type it;
      it.opcode       = op;
      it.address_byte = 8'($urandom);
      it.write_length = 8'($urandom);
      it.ack_bit      = 1'($urandom);
      it.rx_byte      = 8'($urandom);
      it.tx_byte      = 8'($urandom);
      return it;
   endfunction

   // Offer one request beat and hold it until it is accepted.
   task automatic send_req(req_item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= it.opcode;
      req_address_byte <= it.address_byte;
      req_write_length <= it.write_length;
      req_ack_bit      <= it.ack_bit;
      req_rx_byte      <= it.rx_byte;
      req_tx_byte      <= it.tx_byte;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic issue_start(opcode_type op, logic [7:0] addr, logic [7:0] len);
      req_item_type it;
      it = random_item(op);
      it.address_byte = addr;
      it.write_length = len;
      send_req(it);
   endtask

   task automatic issue_ack(logic nack, logic [7:0] tx);
      req_item_type it;
      it = random_item(OP_ACK_REPORT);
      it.ack_bit = nack;
      it.tx_byte = tx;
      send_req(it);
   endtask

   task automatic issue_rx(logic [7:0] b);
      req_item_type it;
      it = random_item(OP_RX_BYTE);
      it.rx_byte = b;
      send_req(it);
   endtask

   // A write: mostly short, now and then any length; NACKs and abandons.
   task automatic run_write_txn();
      int len;
      logic nack;
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
      issue_start(OP_START_WRITE, 8'($urandom), 8'(len));
      for (int i = 0; i <= len; i++) begin
         if ($urandom_range(0, 49) == 0) return;
         nack = ($urandom_range(0, 15) == 0);
         issue_ack(nack, 8'($urandom));
         if (nack) return;
      end
   endtask

   // A read: flagged or length-prefixed, with bad lengths and abandons.
   task automatic run_read_txn();
      logic [7:0] first;
      logic [7:0] len_byte;
      int n;
      issue_start(OP_START_READ, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 11) == 0) begin
         issue_ack(1'b1, 8'($urandom));
         return;
      end
      issue_ack(1'b0, 8'($urandom));
      first = 8'($urandom);
      issue_rx(first);
      if (first[FLAG_BIT]) begin
         n = FIXED_TAIL_LEN;
      end else begin
         if ($urandom_range(0, 6) == 0) len_byte = 8'($urandom_range(128, 255));
         else if ($urandom_range(0, 9) == 0) len_byte = 8'($urandom_range(0, 127));
         else len_byte = 8'($urandom_range(0, 5));
         issue_rx(len_byte);
         if (len_byte >= 8'd128) return;
         n = len_byte + 1;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 40) == 0) return;
         issue_rx(8'($urandom));
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : rsp_sink
      int stall;
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      wait (started);
      forever begin
         if (hold_rsp && !hold_taken) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_taken = 1'b1;
         end
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int pick;
      bit pressure_done;
      sb               = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_ACK_REPORT;
      req_address_byte <= 8'h00;
      req_write_length <= 8'h00;
      req_ack_bit      <= 1'b0;
      req_rx_byte      <= 8'h00;
      req_tx_byte      <= 8'h00;
      items_sent       = 0;
      no_idle          = 1'b0;
      hold_rsp         = 1'b0;
      started          = 1'b0;
      pressure_done    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      started = 1'b1;

      // Reports while idle are ignored.
      issue_ack(1'b0, 8'h5A);
      issue_rx(8'hFF);
      // Empty write ends right after the address ack.
      issue_start(OP_START_WRITE, 8'hFF, 8'h00);
      issue_ack(1'b0, 8'h11);
      // Two data bytes at the extremes; a stray received byte is ignored.
      issue_start(OP_START_WRITE, 8'h00, 8'h02);
      issue_ack(1'b0, 8'hFF);
      issue_rx(8'h33);
      issue_ack(1'b0, 8'h00);
      issue_ack(1'b0, 8'h77);
      // NACK on a data byte fails the write.
      issue_start(OP_START_WRITE, 8'hA5, 8'hFF);
      issue_ack(1'b0, 8'hC3);
      issue_ack(1'b1, 8'h3C);
      // NACK on the read address.
      issue_start(OP_START_READ, 8'h00, 8'h00);
      issue_ack(1'b1, 8'h00);
      // Start while busy abandons the read, then an oversized length fails.
      issue_start(OP_START_READ, 8'hFE, 8'hFF);
      issue_ack(1'b0, 8'h00);
      issue_start(OP_START_READ, 8'h7F, 8'h01);
      issue_ack(1'b0, 8'h00);
      issue_rx(8'h7F);
      issue_rx(8'h80);
      // Flagged first byte: two more bytes follow.
      issue_start(OP_START_READ, 8'h55, 8'h00);
      issue_ack(1'b0, 8'h00);
      issue_rx(8'h80);
      issue_rx(8'h00);
      issue_rx(8'hFF);
      // Length zero: one CRC byte only.
      issue_start(OP_START_READ, 8'hAA, 8'h00);
      issue_ack(1'b0, 8'h00);
      issue_rx(8'h00);
      issue_rx(8'h00);
      issue_rx(8'h3C);

      // Random transactions mixed with noise beats.
      while (items_sent < TOTAL_ITEMS) begin
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            hold_rsp      = 1'b1;
            pressure_done = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
         pick = $urandom_range(0, 9);
         if (pick < 4) run_write_txn();
         else if (pick < 8) run_read_txn();
         else send_req(random_item(opcode_type'($urandom_range(0, 3))));
      end
      req_valid <= 1'b0;

      // Let the owed commands arrive, then allow for late stray beats.
      @(posedge clock);
      while (sb.pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
